// ===== rtl/cat_line_filter_core_macros.svh =====
// Assertion macros shared by the line filter RTL.
`ifndef CAT_LINE_FILTER_CORE_MACROS_SVH
`define CAT_LINE_FILTER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define CLF_ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define CLF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define CLF_ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define CLF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== rtl/clf_pkg.sv =====
// Types, constants and helper functions of the line filter.
`timescale 1ns / 1ps
package clf_pkg;

  localparam int MAX_RESULTS = 25;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int CNT_DIGITS  = 6;
  localparam int DIG_IW      = $clog2(CNT_DIGITS);
  localparam int CFG_IDX_W   = 3;

  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DOLLAR = 8'd36;
  localparam logic [7:0] CH_MINUS  = 8'd45;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_QUEST  = 8'd63;
  localparam logic [7:0] CH_UPPERI = 8'd73;
  localparam logic [7:0] CH_UPPERM = 8'd77;
  localparam logic [7:0] CH_CARET  = 8'd94;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] CTRL_LIMIT  = 8'd32;
  localparam logic [7:0] CTRL_OFFSET = 8'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUMBER_ALL,
    REG_NUMBER_NONBLANK,
    REG_SQUEEZE,
    REG_SHOW_ENDS,
    REG_SHOW_TABS,
    REG_SHOW_NONPRINT
  } cfg_reg_t;

  // Output phases in emission order
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NUM,
    ST_CR,
    ST_BYTE,
    ST_END
  } state_t;

  typedef logic [CNT_DIGITS-1:0][3:0] bcd_t;

  typedef struct packed {
    logic do_num;
    logic do_cr;
    logic do_byte;
    logic do_end;
  } plan_t;

  typedef struct packed {
    state_t phase;
    logic   accept;
    logic   emit;
    logic   last;
  } cmd_t;

  typedef struct packed {
    plan_t plan_now;
    plan_t plan_r;
    logic  phase_end;
    logic  cnt_last;
    logic  out_free;
  } status_t;

  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] b;
  } vis_t;

  // Expand one byte into its visible form, first byte in b[0]
  function automatic vis_t vis_expand(input logic [7:0] c, input logic tabs,
                                      input logic np);
    vis_t       v;
    logic [7:0] lo;
    logic [1:0] k;
    v  = '0;
    lo = c;
    k  = 2'd0;
    if (c == CH_TAB && tabs) begin
      v.b[0] = CH_CARET;
      v.b[1] = CH_UPPERI;
      v.len  = 3'd2;
    end else if (np) begin
      if (c[7]) begin
        v.b[0] = CH_UPPERM;
        v.b[1] = CH_MINUS;
        k      = 2'd2;
        lo     = {1'b0, c[6:0]};
      end
      if (lo == CH_DEL) begin
        v.b[k]        = CH_CARET;
        v.b[k + 2'd1] = CH_QUEST;
        v.len         = {1'b0, k} + 3'd2;
      end else if (lo < CTRL_LIMIT && lo != CH_TAB && lo != CH_LF) begin
        v.b[k]        = CH_CARET;
        v.b[k + 2'd1] = lo + CTRL_OFFSET;
        v.len         = {1'b0, k} + 3'd2;
      end else begin
        v.b[k] = lo;
        v.len  = {1'b0, k} + 3'd1;
      end
    end else begin
      v.b[0] = c;
      v.len  = 3'd1;
    end
    return v;
  endfunction

  // Saturating decimal increment, holds at all nines
  function automatic bcd_t bcd_inc_sat(input bcd_t v);
    bcd_t r;
    logic carry;
    logic full;
    r     = v;
    carry = 1'b1;
    full  = 1'b1;
    for (int i = 0; i < CNT_DIGITS; i++) begin
      if (v[i] != 4'd9) full = 1'b0;
    end
    if (!full) begin
      for (int i = 0; i < CNT_DIGITS; i++) begin
        if (carry) begin
          if (v[i] == 4'd9) begin
            r[i] = 4'd0;
          end else begin
            r[i]  = v[i] + 4'd1;
            carry = 1'b0;
          end
        end
      end
    end
    return r;
  endfunction

  // First planned phase strictly after cur, idle when none remains
  function automatic state_t next_phase(input plan_t p, input state_t cur);
    state_t s;
    if (cur < ST_NUM && p.do_num) s = ST_NUM;
    else if (cur < ST_CR && p.do_cr) s = ST_CR;
    else if (cur < ST_BYTE && p.do_byte) s = ST_BYTE;
    else if (cur < ST_END && p.do_end) s = ST_END;
    else s = ST_IDLE;
    return s;
  endfunction

endpackage

// ===== rtl/clf_ctrl.sv =====
// Sequencer that walks the output phases of one input item.
`timescale 1ns / 1ps
`include "cat_line_filter_core_macros.svh"
module clf_ctrl
  import clf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  state_t after_cur;

  assign after_cur = next_phase(st.plan_r, state_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = next_phase(st.plan_now, ST_IDLE);
      end
      ST_NUM, ST_CR, ST_BYTE, ST_END: begin
        if (st.out_free) begin
          if (st.cnt_last) state_nxt = ST_IDLE;
          else if (st.phase_end) state_nxt = after_cur;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.phase  = state_r;
    cmd.accept = 1'b0;
    cmd.emit   = 1'b0;
    cmd.last   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_NUM, ST_CR, ST_BYTE, ST_END: begin
        cmd.emit = st.out_free;
        // last byte of the item, or the result budget runs out
        cmd.last = st.cnt_last || (st.phase_end && after_cur == ST_IDLE);
      end
      default: ;
    endcase
  end

  `CLF_ASSERT_NEXT(a_last_ends_item, clk, rst_n, cmd.emit && cmd.last, state_r == ST_IDLE, "item did not end after last byte")
  `CLF_ASSERT_ALWAYS(a_cr_phase_planned, clk, rst_n, state_r != ST_CR || st.plan_r.do_cr, "CR phase entered without held CRs")

endmodule

// ===== rtl/clf_datapath.sv =====
// Line state, counters, configuration and output byte generation.
`timescale 1ns / 1ps
`include "cat_line_filter_core_macros.svh"
module clf_datapath
  import clf_pkg::*;
#(
  parameter int HELD_CR_MAX  = 8,
  parameter int NUMBER_WIDTH = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data,
  input  logic                 in_func,
  input  logic [7:0]           in_data_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_out_byte,
  output logic                 out_last_of_run,
  input  cmd_t                 cmd,
  output status_t              st
);

  localparam int NUM_LEN_MAX = ((NUMBER_WIDTH > CNT_DIGITS) ? NUMBER_WIDTH : CNT_DIGITS) + 1;
  localparam int IDX_W       = $clog2(NUM_LEN_MAX + 1);
  localparam int HW          = $clog2(HELD_CR_MAX + 1);

  logic number_all_r, number_nb_r, squeeze_r, show_ends_r, show_tabs_r, show_np_r;

  logic          mid_line_r, mid_line_nxt;
  logic [HW-1:0] held_r, held_nxt;
  logic          prev_empty_r, prev_empty_nxt;
  bcd_t          line_r, line_nxt;
  bcd_t          nb_r, nb_nxt;
  logic [HW-1:0] cr_left_r, cr_left_nxt;
  plan_t         plan_r, plan_nxt;
  logic [7:0]    byte_r;
  logic [IDX_W-1:0] idx_r;
  logic [CNT_W-1:0] out_cnt_r;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  // Classify the offered item and work out its state change and output plan
  always_comb begin
    logic fin_empty, fin_nl, start_ne, skip;
    fin_empty      = 1'b0;
    fin_nl         = 1'b0;
    start_ne       = 1'b0;
    skip           = 1'b0;
    plan_nxt       = '0;
    mid_line_nxt   = mid_line_r;
    held_nxt       = held_r;
    prev_empty_nxt = prev_empty_r;
    line_nxt       = line_r;
    nb_nxt         = nb_r;
    cr_left_nxt    = held_r;
    if (in_func) begin
      fin_empty    = (held_r != '0);
      mid_line_nxt = 1'b0;
    end else if (mid_line_r) begin
      if (in_data_byte == CH_LF) begin
        plan_nxt.do_end = 1'b1;
        mid_line_nxt    = 1'b0;
      end else begin
        plan_nxt.do_byte = 1'b1;
      end
    end else if (in_data_byte == CH_LF) begin
      fin_empty = 1'b1;
      fin_nl    = 1'b1;
    end else if (in_data_byte == CH_CR) begin
      if (held_r == HW'(HELD_CR_MAX - 1)) start_ne = 1'b1;
      else held_nxt = held_r + HW'(1);
    end else begin
      start_ne = 1'b1;
    end

    if (start_ne) begin
      prev_empty_nxt   = 1'b0;
      plan_nxt.do_num  = number_all_r || number_nb_r;
      plan_nxt.do_cr   = (held_r != '0);
      plan_nxt.do_byte = 1'b1;
      if (number_nb_r) nb_nxt = bcd_inc_sat(nb_r);
      if (number_all_r) line_nxt = bcd_inc_sat(line_r);
      held_nxt     = '0;
      mid_line_nxt = 1'b1;
    end

    if (fin_empty) begin
      skip           = squeeze_r && prev_empty_r;
      prev_empty_nxt = squeeze_r;
      if (!skip) begin
        plan_nxt.do_num = number_all_r;
        plan_nxt.do_cr  = (held_r != '0);
        plan_nxt.do_end = fin_nl;
        if (number_all_r) line_nxt = bcd_inc_sat(line_r);
      end
      held_nxt     = '0;
      mid_line_nxt = 1'b0;
    end
  end

  // Line number bytes: pad, digits, tab
  bcd_t             num_sel;
  logic [IDX_W-1:0] n_dig, pad_len, num_len, dig_pos;
  logic [3:0]       dig_val;
  logic [7:0]       num_byte;

  always_comb begin
    num_sel = number_all_r ? line_r : nb_r;
    n_dig   = IDX_W'(1);
    for (int i = 1; i < CNT_DIGITS; i++) begin
      if (num_sel[i] != 4'd0) n_dig = IDX_W'(i + 1);
    end
    pad_len = (IDX_W'(NUMBER_WIDTH) > n_dig) ? IDX_W'(NUMBER_WIDTH) - n_dig : '0;
    num_len = pad_len + n_dig + IDX_W'(1);
    dig_pos = pad_len + n_dig - IDX_W'(1) - idx_r;
    dig_val = num_sel[dig_pos[DIG_IW-1:0]];
    if (idx_r < pad_len) num_byte = CH_SPACE;
    else if (idx_r < pad_len + n_dig) num_byte = CH_ZERO | {4'b0, dig_val};
    else num_byte = CH_TAB;
  end

  vis_t cr_vis, byte_vis;
  assign cr_vis   = vis_expand(CH_CR, show_tabs_r, show_np_r);
  assign byte_vis = vis_expand(byte_r, show_tabs_r, show_np_r);

  logic [7:0] cur_byte;
  logic       phase_end;

  always_comb begin
    cur_byte  = CH_LF;
    phase_end = 1'b1;
    case (cmd.phase)
      ST_NUM: begin
        cur_byte  = num_byte;
        phase_end = (idx_r == num_len - IDX_W'(1));
      end
      ST_CR: begin
        cur_byte  = cr_vis.b[idx_r[1:0]];
        phase_end = (idx_r == IDX_W'(cr_vis.len - 3'd1)) && (cr_left_r == HW'(1));
      end
      ST_BYTE: begin
        cur_byte  = byte_vis.b[idx_r[1:0]];
        phase_end = (idx_r == IDX_W'(byte_vis.len - 3'd1));
      end
      ST_END: begin
        cur_byte  = (show_ends_r && idx_r == '0) ? CH_DOLLAR : CH_LF;
        phase_end = show_ends_r ? (idx_r == IDX_W'(1)) : 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_all_r <= 1'b0;
      number_nb_r  <= 1'b0;
      squeeze_r    <= 1'b0;
      show_ends_r  <= 1'b0;
      show_tabs_r  <= 1'b0;
      show_np_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUMBER_ALL:      number_all_r <= cfg_data;
        REG_NUMBER_NONBLANK: number_nb_r  <= cfg_data;
        REG_SQUEEZE:         squeeze_r    <= cfg_data;
        REG_SHOW_ENDS:       show_ends_r  <= cfg_data;
        REG_SHOW_TABS:       show_tabs_r  <= cfg_data;
        REG_SHOW_NONPRINT:   show_np_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_line_r   <= 1'b0;
      held_r       <= '0;
      prev_empty_r <= 1'b0;
      line_r       <= '0;
      nb_r         <= '0;
      cr_left_r    <= '0;
      plan_r       <= '0;
      idx_r        <= '0;
      out_cnt_r    <= '0;
    end else if (cmd.accept) begin
      mid_line_r   <= mid_line_nxt;
      held_r       <= held_nxt;
      prev_empty_r <= prev_empty_nxt;
      line_r       <= line_nxt;
      nb_r         <= nb_nxt;
      cr_left_r    <= cr_left_nxt;
      plan_r       <= plan_nxt;
      idx_r        <= '0;
      out_cnt_r    <= '0;
    end else if (cmd.emit) begin
      out_cnt_r <= out_cnt_r + CNT_W'(1);
      if (cmd.phase == ST_CR) begin
        // advance through the visible form of each held CR
        if (idx_r == IDX_W'(cr_vis.len - 3'd1)) begin
          idx_r     <= '0;
          cr_left_r <= cr_left_r - HW'(1);
        end else begin
          idx_r <= idx_r + IDX_W'(1);
        end
      end else if (phase_end) begin
        idx_r <= '0;
      end else begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) byte_r <= in_data_byte;
  end

  // Output register parts the sequencer from the downstream stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r <= cur_byte;
      out_last_r <= cmd.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_out_byte    = out_byte_r;
  assign out_last_of_run = out_last_r;

  assign st.plan_now  = plan_nxt;
  assign st.plan_r    = plan_r;
  assign st.phase_end = phase_end;
  assign st.cnt_last  = (out_cnt_r == CNT_W'(MAX_RESULTS - 1));
  assign st.out_free  = !out_valid_r || out_ready;

  `CLF_ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, out_cnt_r <= CNT_W'(MAX_RESULTS), "result count past limit")
  `CLF_ASSERT_ALWAYS(a_held_bound, clk, rst_n, held_r < HW'(HELD_CR_MAX), "held CR count past bound")

endmodule

// ===== rtl/cat_line_filter_core.sv =====
// Each input item is taken only while the sequencer is idle; no new item is taken before
// the last output byte of the current one has been emitted. An item with output moves
// the state register out of idle, and each of its bytes then passes the output register.
// The phase sequencer emits one byte per cycle into the output register while it is free.
// Reset (synchronous, rst_n low) clears configuration, line state and counters.
`timescale 1ns / 1ps
module cat_line_filter_core
  import clf_pkg::*;
#(
  parameter int HELD_CR_MAX  = 8,
  parameter int NUMBER_WIDTH = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_func,
  input  logic [7:0]           in_data_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_out_byte,
  output logic                 out_last_of_run
);

  cmd_t    cmd;
  status_t st;

  clf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  clf_datapath #(
    .HELD_CR_MAX  (HELD_CR_MAX),
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_func         (in_func),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_out_byte    (out_out_byte),
    .out_last_of_run (out_last_of_run),
    .cmd             (cmd),
    .st              (st)
  );

endmodule

// ===== tb/clf_tb_pkg.sv =====
// Input function codes shared by the line filter testbench files.
`timescale 1ns / 1ps
package clf_tb_pkg;

  localparam logic FUNC_DATA = 1'b0;
  localparam logic FUNC_EOF  = 1'b1;

endpackage

// ===== tb/cat_line_filter_checker.sv =====
// Line filter checker: predicts the output byte stream and compares every output transfer.
`timescale 1ns / 1ps
module cat_line_filter_checker
  import clf_pkg::*;
  import clf_tb_pkg::*;
#(
  parameter int HELD_CR_MAX  = 8,
  parameter int NUMBER_WIDTH = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_func,
  input  logic [7:0]           in_data_byte,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [7:0]           out_out_byte,
  input  logic                 out_last_of_run,
  output int                   err_count,
  output int                   open_count
);

  localparam int unsigned COUNT_CAP = 999999;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } out_beat_t;

  out_beat_t   expected_q[$];
  logic [7:0]  run_q[$];

  logic        num_all, num_nonblank, squeeze, show_ends, show_tabs, show_np;
  logic        in_line, prev_blank;
  int          held_crs;
  int unsigned line_no, text_line_no;

  function automatic void emit(input logic [7:0] c);
    if (run_q.size() < MAX_RESULTS) run_q.push_back(c);
  endfunction

  function automatic void emit_visible(input logic [7:0] c);
    logic [7:0] lo;
    lo = c;
    if (c == CH_TAB && show_tabs) begin
      emit(CH_CARET);
      emit(CH_UPPERI);
      return;
    end
    if (show_np) begin
      if (lo[7]) begin
        emit(CH_UPPERM);
        emit(CH_MINUS);
        lo[7] = 1'b0;
      end
      if (lo == CH_DEL) begin
        emit(CH_CARET);
        emit(CH_QUEST);
        return;
      end
      if (lo < CTRL_LIMIT && lo != CH_TAB && lo != CH_LF) begin
        emit(CH_CARET);
        emit(lo + CTRL_OFFSET);
        return;
      end
    end
    emit(lo);
  endfunction

  function automatic void emit_number(input int unsigned v);
    logic [7:0] digits[10];
    int         nd;
    nd = 0;
    do begin
      digits[nd] = CH_ZERO + 8'(v % 10);
      v = v / 10;
      nd++;
    end while (v != 0 && nd < 10);
    for (int i = nd; i < NUMBER_WIDTH; i++) emit(CH_SPACE);
    for (int i = nd - 1; i >= 0; i--) emit(digits[i]);
    emit(CH_TAB);
  endfunction

  function automatic void number_line(input logic blank);
    if (num_all || (num_nonblank && !blank)) begin
      if (num_nonblank && !blank && text_line_no < COUNT_CAP) text_line_no++;
      if (num_all && line_no < COUNT_CAP) line_no++;
      emit_number(num_all ? line_no : text_line_no);
    end
  endfunction

  function automatic void flush_crs();
    for (int k = 0; k < held_crs; k++) emit_visible(CH_CR);
    held_crs = 0;
  endfunction

  function automatic void open_text_line();
    prev_blank = 1'b0;
    number_line(1'b0);
    flush_crs();
    in_line = 1'b1;
  endfunction

  function automatic void close_empty(input logic with_nl);
    logic skip;
    skip = 1'b0;
    if (squeeze) begin
      skip       = prev_blank;
      prev_blank = 1'b1;
    end else begin
      prev_blank = 1'b0;
    end
    // a squeezed line drops its held CRs too
    if (!skip) begin
      number_line(1'b1);
      flush_crs();
      if (with_nl) begin
        if (show_ends) emit(CH_DOLLAR);
        emit(CH_LF);
      end
    end
    held_crs = 0;
    in_line  = 1'b0;
  endfunction

  function automatic void predict_run(input logic func, input logic [7:0] b);
    out_beat_t beat;
    run_q.delete();
    if (func == FUNC_EOF) begin
      if (held_crs > 0) close_empty(1'b0);
      in_line = 1'b0;
    end else if (in_line) begin
      if (b == CH_LF) begin
        if (show_ends) emit(CH_DOLLAR);
        emit(CH_LF);
        in_line = 1'b0;
      end else begin
        emit_visible(b);
      end
    end else if (b == CH_LF) begin
      close_empty(1'b1);
    end else if (b == CH_CR) begin
      // hold leading CRs until the line is classified or the bound is hit
      if (held_crs + 1 >= HELD_CR_MAX) begin
        open_text_line();
        emit_visible(CH_CR);
      end else begin
        held_crs++;
      end
    end else begin
      open_text_line();
      emit_visible(b);
    end
    foreach (run_q[i]) begin
      beat.ch   = run_q[i];
      beat.last = (i == run_q.size() - 1);
      expected_q.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      num_all      = 1'b0;
      num_nonblank = 1'b0;
      squeeze      = 1'b0;
      show_ends    = 1'b0;
      show_tabs    = 1'b0;
      show_np      = 1'b0;
      in_line      = 1'b0;
      prev_blank   = 1'b0;
      held_crs     = 0;
      line_no      = 0;
      text_line_no = 0;
      err_count    = 0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_NUMBER_ALL:      num_all      = cfg_data;
          REG_NUMBER_NONBLANK: num_nonblank = cfg_data;
          REG_SQUEEZE:         squeeze      = cfg_data;
          REG_SHOW_ENDS:       show_ends    = cfg_data;
          REG_SHOW_TABS:       show_tabs    = cfg_data;
          REG_SHOW_NONPRINT:   show_np      = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_run(in_func, in_data_byte);
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("out_byte: expected no transfer, actual %0h", out_out_byte);
          err_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_out_byte !== want.ch) begin
            $error("out_byte: expected %0h, actual %0h", want.ch, out_out_byte);
            err_count++;
          end
          if (out_last_of_run !== want.last) begin
            $error("last_of_run: expected %0b, actual %0b", want.last, out_last_of_run);
            err_count++;
          end
        end
      end
    end
    open_count = expected_q.size();
  end

endmodule

// ===== tb/tb_cat_line_filter_core.sv =====
// Testbench top for the line filter: stimulus, random idling and the final verdict.
`timescale 1ns / 1ps
module tb_cat_line_filter_core;
  import clf_pkg::*;
  import clf_tb_pkg::*;

  localparam int         HELD_CR_MAX   = 8;
  localparam int         NUMBER_WIDTH  = 6;
  localparam int         MAX_GAP       = 16;
  localparam int         DRAIN_CYCLES  = 40;
  localparam int         CYCLE_LIMIT   = 600000;
  localparam int         RANDOM_PHASES = 6;
  localparam int         PHASE_ITEMS   = 36;
  localparam logic [5:0] FLAGS_NONE    = 6'h00;
  localparam logic [5:0] FLAGS_ALL     = 6'h3F;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic                 cfg_data     = 1'b0;
  logic                 in_valid     = 1'b0;
  logic                 in_func      = FUNC_DATA;
  logic [7:0]           in_data_byte = '0;
  logic                 out_ready    = 1'b0;
  logic                 in_ready;
  logic                 out_valid;
  logic [7:0]           out_out_byte;
  logic                 out_last_of_run;

  int   err_count;
  int   open_count;
  int   cycle_count = 0;
  int   phase_items = 0;
  int   out_hold    = 0;
  logic in_calm     = 1'b0;
  logic out_calm    = 1'b0;
  logic out_took    = 1'b0;

  cat_line_filter_core #(
    .HELD_CR_MAX (HELD_CR_MAX),
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_out_byte   (out_out_byte),
    .out_last_of_run(out_last_of_run)
  );

  cat_line_filter_checker #(
    .HELD_CR_MAX (HELD_CR_MAX),
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_out_byte   (out_out_byte),
    .out_last_of_run(out_last_of_run),
    .err_count      (err_count),
    .open_count     (open_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Draw a fresh stall after every output transfer
  always @(posedge clk) out_took <= out_valid && out_ready;

  always @(negedge clk) begin
    int hold;
    hold = out_hold;
    if (out_took) begin
      if ($urandom_range(0, 31) == 0) out_calm = ~out_calm;
      hold = out_calm ? 0 : $urandom_range(0, MAX_GAP);
    end
    if (hold > 0) begin
      out_ready <= 1'b0;
      hold--;
    end else begin
      out_ready <= 1'b1;
    end
    out_hold = hold;
  end

  // Starts and ends at a falling edge; valid stays high after the transfer
  task automatic send_item(input logic func, input logic [7:0] data);
    int gap;
    if ($urandom_range(0, 31) == 0) in_calm = ~in_calm;
    gap = in_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= func;
    in_data_byte <= data;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    phase_items++;
  endtask

  task automatic send_byte(input logic [7:0] data);
    send_item(FUNC_DATA, data);
  endtask

  task automatic send_eof();
    send_item(FUNC_EOF, 8'($urandom_range(0, 255)));
  endtask

  // Drain all expected bytes, then let the sequencer finish silent items
  task automatic settle();
    in_valid <= 1'b0;
    while (open_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_flags(input logic [5:0] flags);
    cfg_reg_t r;
    r = r.first();
    repeat (r.num()) begin
      cfg_we    <= 1'b1;
      cfg_index <= r;
      cfg_data  <= flags[int'(r)];
      @(negedge clk);
      r = r.next();
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] text_char();
    case ($urandom_range(0, 9))
      0:       return CH_TAB;
      1:       return CH_CR;
      2:       return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(32, 126));
    endcase
  endfunction

  task automatic send_random_line();
    int n;
    case ($urandom_range(0, 9))
      0, 1: send_byte(CH_LF);
      2: begin
        n = $urandom_range(1, HELD_CR_MAX + 2);
        repeat (n) send_byte(CH_CR);
        send_byte(CH_LF);
      end
      3: begin
        n = $urandom_range(1, HELD_CR_MAX + 1);
        repeat (n) send_byte(CH_CR);
        send_eof();
      end
      9: begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          send_item($urandom_range(0, 1) ? FUNC_EOF : FUNC_DATA, 8'($urandom_range(0, 255)));
        end
      end
      default: begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n) send_byte(CH_CR);
        n = $urandom_range(0, 10);
        repeat (n) send_byte(text_char());
        send_byte(CH_LF);
      end
    endcase
  endtask

  initial begin
    logic [5:0] flags;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: everything passes through
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_LF);
    send_byte(CH_LF);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_eof();
    settle();

    write_flags(FLAGS_ALL);
    send_byte(CH_LF);
    send_byte(CH_LF);
    send_byte(CH_CR);
    send_eof();
    repeat (HELD_CR_MAX) send_byte(CH_CR);
    send_byte(CH_TAB);
    send_byte(8'h9F);
    send_byte(8'hFF);
    send_byte(CH_DEL);
    send_byte(CH_LF);
    settle();

    flags                      = FLAGS_NONE;
    flags[REG_NUMBER_NONBLANK] = 1'b1;
    flags[REG_SHOW_NONPRINT]   = 1'b1;
    write_flags(flags);
    send_byte(CH_TAB);
    send_byte(CH_LF);
    send_byte(CH_CR);
    send_eof();
    send_byte(8'h61);
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) flags = FLAGS_NONE;
      else if (p == 1) flags = FLAGS_ALL;
      else flags = 6'($urandom_range(0, 63));
      write_flags(flags);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) send_random_line();
      settle();
    end

    if (err_count == 0 && open_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
